/* src/erf_pkg.sv */
// erf_pkg: types and constants shared by the etherbone request framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package erf_pkg;

  localparam int unsigned MAX_READS   = 60;
  localparam int unsigned CMDQ_DEPTH  = 4;
  localparam int unsigned CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam int unsigned IDX_W       = 7;

  localparam logic [31:0] HDR_WORD0      = 32'h4E6F_1044;
  localparam logic [31:0] HDR_WORD2_BASE = 32'h000F_0000;
  localparam logic [31:0] ADDR_STEP      = 32'd4;

  localparam logic [IDX_W-1:0] IDX_HDR0 = 7'd0;
  localparam logic [IDX_W-1:0] IDX_HDR1 = 7'd1;
  localparam logic [IDX_W-1:0] IDX_HDR2 = 7'd2;
  localparam logic [IDX_W-1:0] IDX_BASE = 7'd3;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_DATA  = 2'd2,
    REQ_BAD   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_ERROR = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [7:0]  word_count;
    logic [31:0] data_word;
  } item_t;

  typedef struct packed {
    logic [31:0] packet_word;
    logic        last_word;
    logic        error;
  } result_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] value;
    logic [7:0]  count;
    logic        last;
  } cmd_t;

endpackage

`default_nettype wire

/* src/etherbone_request_framer.sv */
// etherbone_request_framer: top level, front checker, command queue, word sequencer
// depends on erf_pkg, erf_front, erf_cmd_queue, erf_back
// when idle, an item goes through the command queue, then the output register
// one input item per cycle unless full; one result word per cycle while popped
// a read request gives 4 + word_count back words, a write header 4, others 1
// reset: synchronous, clears the pending write count, queue pointers and output valid
`timescale 1ns / 1ps
`default_nettype none

module etherbone_request_framer import erf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result
);

  logic cmdq_full;
  logic cmdq_push;
  cmd_t cmdq_wdata;
  cmd_t cmdq_rdata;
  logic cmdq_valid;
  logic cmdq_pop;

  erf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmdq_full (cmdq_full),
    .cmdq_push (cmdq_push),
    .cmdq_data (cmdq_wdata)
  );

  erf_cmd_queue u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmdq_push),
    .wr_data (cmdq_wdata),
    .q_full  (cmdq_full),
    .rd_en   (cmdq_pop),
    .rd_data (cmdq_rdata),
    .q_valid (cmdq_valid)
  );

  erf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (cmdq_valid),
    .cmd     (cmdq_rdata),
    .q_pop   (cmdq_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

/* src/erf_front.sv */
// erf_front: accepts request items, checks them against the pending write
// depends on erf_pkg
`timescale 1ns / 1ps
`default_nettype none

module erf_front import erf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  input  wire logic  cmdq_full,
  output logic       cmdq_push,
  output cmd_t       cmdq_data
);

  logic [7:0] writes_remaining;
  logic [7:0] writes_remaining_next;

  assign full      = cmdq_full;
  assign cmdq_push = push && !cmdq_full;

  always_comb begin
    writes_remaining_next = writes_remaining;
    cmdq_data.kind        = CMD_ERROR;
    cmdq_data.value       = item.address;
    cmdq_data.count       = item.word_count;
    cmdq_data.last        = 1'b0;
    case (req_type_t'(item.req_type))
      REQ_READ: begin
        if (writes_remaining == 8'd0 && item.word_count <= 8'(MAX_READS)) begin
          cmdq_data.kind = CMD_READ;
        end
      end
      REQ_WRITE: begin
        if (writes_remaining == 8'd0) begin
          cmdq_data.kind        = CMD_WRITE;
          writes_remaining_next = item.word_count;
        end
      end
      REQ_DATA: begin
        if (writes_remaining != 8'd0) begin
          cmdq_data.kind        = CMD_DATA;
          cmdq_data.value       = item.data_word;
          cmdq_data.last        = (writes_remaining == 8'd1);
          writes_remaining_next = writes_remaining - 8'd1;
        end
      end
      default: begin
        cmdq_data.kind = CMD_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      writes_remaining <= 8'd0;
    end else if (cmdq_push) begin
      writes_remaining <= writes_remaining_next;
    end
  end

endmodule

`default_nettype wire

/* src/erf_cmd_queue.sv */
// erf_cmd_queue: short command queue between front and back
// depends on erf_pkg
`timescale 1ns / 1ps
`default_nettype none

module erf_cmd_queue import erf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      q_full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      q_valid
);

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   fill;

  assign q_full  = (fill == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign q_valid = (fill != '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/erf_back.sv */
// erf_back: expands queued commands into packet words, one per cycle
// while results are popped; depends on erf_pkg
`timescale 1ns / 1ps
`default_nettype none

module erf_back import erf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cmd_t cmd,
  output logic      q_pop,
  output logic      empty,
  input  wire logic pop,
  output result_t   result
);

  logic [IDX_W-1:0] idx;
  logic [31:0]      addr_acc;
  logic             out_valid;
  logic             advance;
  logic             issue;
  logic             final_word;
  result_t          word;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign issue   = advance && q_valid;
  assign q_pop   = issue && final_word;

  // word for the current index of the head command
  always_comb begin
    word       = '0;
    final_word = 1'b1;
    case (cmd.kind)
      CMD_READ, CMD_WRITE: begin
        final_word = (cmd.kind == CMD_READ)
                   ? (idx == IDX_BASE + IDX_W'(cmd.count))
                   : (idx == IDX_BASE);
        case (idx)
          IDX_HDR0: word.packet_word = HDR_WORD0;
          IDX_HDR1: word.packet_word = 32'd0;
          IDX_HDR2: begin
            word.packet_word = (cmd.kind == CMD_READ)
                             ? (HDR_WORD2_BASE | {24'd0, cmd.count})
                             : (HDR_WORD2_BASE | {16'd0, cmd.count, 8'd0});
          end
          IDX_BASE: begin
            word.packet_word = (cmd.kind == CMD_READ) ? 32'd0 : cmd.value;
            word.last_word   = (cmd.count == 8'd0);
          end
          default: begin
            word.packet_word = addr_acc;
            word.last_word   = final_word;
          end
        endcase
      end
      CMD_DATA: begin
        word.packet_word = cmd.value;
        word.last_word   = cmd.last;
      end
      default: begin
        word.error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      result <= word;
      if (idx == IDX_BASE) begin
        addr_acc <= cmd.value;
      end else begin
        addr_acc <= addr_acc + ADDR_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= q_valid;
      end
      if (issue) begin
        idx <= final_word ? '0 : idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/erf_checker.sv */
// erf_checker: port-level assertions for the request framer, bound to the top
// depends on erf_pkg and etherbone_request_framer
`timescale 1ns / 1ps
`default_nettype none

module erf_checker import erf_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    push,
  input wire logic    full,
  input wire item_t   item,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t result
);

  // error results carry a zero word and no last mark
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.error) |-> (result.packet_word == 32'd0 && !result.last_word))
    else $error("error result with nonzero word or last");

  // a result not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while waiting");

  // reset leaves both sides idle
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not idle after reset");

  // an unknown request type into an idle block gives an error result through the queue and the output register
  a_bad_type: assert property (@(posedge clk) disable iff (rst)
    (push && !full && item.req_type == REQ_BAD && empty && !$past(push && !full))
      |=> ##1 (!empty && result.error))
    else $error("unknown request type not rejected");

endmodule

bind etherbone_request_framer erf_checker u_erf_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
